// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: sizes, request
// codes, status codes, beat payloads and the control/status bundles.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int REQ_W      = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]             req_type;
    logic signed [DATA_WIDTH-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [1:0]                   status;
    logic                         is_empty_now;
    logic [CNT_W-1:0]             entry_count;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // request taken this cycle
    logic    ins_back;
    logic    ins_front;
    logic    pop_front;
    logic    pop_back;
    logic    rd_en;       // result carries a data word
    logic    rd_back;     // read the back slot, else the front slot
    status_t status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// ----- rtl/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake controller and request decoder. Holds the result-pending state
// and turns each taken request into datapath commands.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REQ_W-1:0] req_type,
  output logic             out_valid,
  input  logic             out_ready,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;
  logic   is_push;
  logic   is_read;

  assign in_ready  = (state == S_IDLE) || out_ready;
  assign out_valid = (state == S_HOLD);
  assign take      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready && !take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    is_push = (req_type == REQ_PUSH_BACK) || (req_type == REQ_PUSH_FRONT);
    is_read = (req_type == REQ_POP_FRONT) || (req_type == REQ_POP_BACK) ||
              (req_type == REQ_PEEK_FRONT) || (req_type == REQ_PEEK_BACK);

    cmd            = '0;
    cmd.load       = take;
    cmd.status     = ST_OK;
    if (is_push && stat.full)       cmd.status = ST_FULL;
    else if (is_read && stat.empty) cmd.status = ST_EMPTY;

    cmd.rd_back    = (req_type == REQ_POP_BACK) || (req_type == REQ_PEEK_BACK);
    cmd.rd_en      = is_read && !stat.empty;
    cmd.ins_back   = take && !stat.full && (req_type == REQ_PUSH_BACK);
    cmd.ins_front  = take && !stat.full && (req_type == REQ_PUSH_FRONT);
    cmd.pop_front  = take && !stat.empty && (req_type == REQ_POP_FRONT);
    cmd.pop_back   = take && !stat.empty && (req_type == REQ_POP_BACK);
  end

  // no new request while a result waits on a stalled output
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && !out_ready) |-> !cmd.load)
    else $error("request taken over a pending result");

  // pops never issued on an empty queue, pushes never on a full one
  a_pop_guard: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_back) |-> !stat.empty)
    else $error("pop on empty queue");

  a_push_guard: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_front || cmd.ins_back) |-> !stat.full)
    else $error("push on full queue");

endmodule

// ----- rtl/deq_dpath.sv -----
// ----------------------------------------------------------------------------
// deq_dpath
// Ring buffer storage, front pointer, entry count and result registers.
// ----------------------------------------------------------------------------
module deq_dpath import deq_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  output dp_stat_t                     stat,
  output logic signed [DATA_WIDTH-1:0] read_value,
  output status_t                      status,
  output logic [CNT_W-1:0]             count
);

  // base + off modulo DEPTH, off at most DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_q;
  logic                         rd_en_q;
  logic [IDX_W-1:0]             front;
  logic [IDX_W-1:0]             front_next;
  logic [CNT_W-1:0]             count_next;
  logic [IDX_W-1:0]             front_dec;
  logic [IDX_W-1:0]             tail_pos;
  logic [IDX_W-1:0]             back_pos;
  logic [IDX_W-1:0]             wr_addr;
  logic [IDX_W-1:0]             rd_addr;
  logic                         wr_en;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

  always_comb begin
    front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
    tail_pos  = ring_add(front, count);
    back_pos  = ring_add(front, count - CNT_W'(1));
    wr_en     = cmd.ins_back || cmd.ins_front;
    wr_addr   = cmd.ins_front ? front_dec : tail_pos;
    rd_addr   = cmd.rd_back ? back_pos : front;

    front_next = front;
    count_next = count;
    if (cmd.ins_front) front_next = front_dec;
    if (cmd.pop_front) front_next = ring_add(front, CNT_W'(1));
    if (wr_en)                         count_next = count + CNT_W'(1);
    if (cmd.pop_front || cmd.pop_back) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= push_value;
  end

  // registered read doubles as the result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_q    <= mem[rd_addr];
      rd_en_q <= cmd.rd_en;
      status  <= cmd.status;
    end
  end

  assign read_value = rd_en_q ? rd_q : '0;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count out of range");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> count == $past(count) + CNT_W'(1))
    else $error("push did not bump count");

  a_err_stable: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && cmd.status != ST_OK) |=> ($stable(count) && $stable(front)))
    else $error("error request changed the queue");

endmodule

// ----- rtl/double_ended_queue_top.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit words in a 16-entry ring buffer.
//
// Each request beat on the input channel pushes at the back or front, pops
// the front or back, or peeks at either end, and yields exactly one result
// beat: the word read (zero for pushes, errors and unused request codes), a
// status (ok, empty error, full error), an empty flag and the entry count
// after the request. Errors leave the queue untouched; a push on a full
// queue drops its word. A request is taken in the cycle its beat is
// accepted and its result is presented from the next cycle on, so the block
// sustains one request per cycle unless the output stalls. The result sits
// in a single output register that is also the storage read register; a
// new request is taken whenever that register is empty or being emptied in
// the same cycle, so a stalled output stalls the input. The single-write,
// single-read storage array has no reset; results carry only written words.
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  dp_cmd_t                      cmd;
  dp_stat_t                     stat;
  logic signed [DATA_WIDTH-1:0] read_value;
  status_t                      status;
  logic [CNT_W-1:0]             count;

  // handshake and request decode
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (in_data.req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // pointers, count, storage and result registers
  deq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (in_data.push_value),
    .stat       (stat),
    .read_value (read_value),
    .status     (status),
    .count      (count)
  );

  // count only moves on a taken request, so it is stable while a result waits
  always_comb begin
    out_data.read_value   = read_value;
    out_data.status       = status;
    out_data.is_empty_now = stat.empty;
    out_data.entry_count  = count;
  end

endmodule
